>>> rtl/dse_pkg.sv
`default_nettype none
// ============================================================================
// dse_pkg
// Shared types, constants and helpers of the delimited span extractor.
// ============================================================================
package dse_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 4;
    localparam int PATTERN_BYTES = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_PATTERN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_PATTERN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_LENGTH  = 2'd3;

    localparam int DEFAULT_MAX_DELIM_LEN = 8;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_LEFT  = 2'd0,
        PH_RIGHT = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    // One text byte's worth of results, as handed from the front to the back.
    typedef struct packed {
        logic       span_v;
        logic [7:0] span_byte;
        logic       end_v;
        logic       found;
    } result_pair_t;

    // Byte k of a delimiter pattern; bytes past the eighth read as zero.
    function automatic logic [7:0] pat_byte(input logic [CFG_DATA_W-1:0] pat,
                                            input int unsigned k);
        logic [7:0] b;
        b = 8'd0;
        if (k < PATTERN_BYTES)
        begin
            b = pat[8*k +: 8];
        end
        return b;
    endfunction

endpackage
`default_nettype wire

>>> rtl/dse_stream_if.sv
`default_nettype none
// ============================================================================
// dse_stream_if
// Valid/ready channels for source text bytes and extracted results.
// ============================================================================
interface dse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface dse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] span_byte;
    logic       is_end;
    logic       found;

    modport source (output valid, output span_byte, output is_end, output found,
                    input ready);
    modport sink   (input valid, input span_byte, input is_end, input found,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/dse_front.sv
`default_nettype none
// ============================================================================
// dse_front
// Accepts text bytes, holds the delimiter registers and the byte window,
// matches both delimiters and classifies each request into its results.
// ============================================================================
module dse_front #(
    parameter int MAX_DELIM_LEN = dse_pkg::DEFAULT_MAX_DELIM_LEN
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dse_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    dse_in_if.sink                                text_in,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output dse_pkg::result_pair_t                 q_entry
);
    import dse_pkg::*;

    localparam int CNT_W = $clog2(MAX_DELIM_LEN + 1);
    localparam int IDX_W = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

    typedef logic [MAX_DELIM_LEN-1:0][7:0] byte_win_t;

    logic [CFG_DATA_W-1:0] left_pattern_reg;
    logic [LEN_W-1:0]      left_length_reg;
    logic [CFG_DATA_W-1:0] right_pattern_reg;
    logic [LEN_W-1:0]      right_length_reg;

    phase_t           phase_reg, phase_next;
    byte_win_t        win_reg, win_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    byte_win_t        win_shift;
    logic [CNT_W-1:0] fill_shift;
    logic [CNT_W-1:0] ll, rl;
    logic [IDX_W-1:0] rl_idx;
    logic             accept;
    logic             left_hit, right_hit;

    // Lengths of zero act as one; lengths past the window act as the window.
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] r;
        if (int'(len) == 0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(len) > MAX_DELIM_LEN)
        begin
            r = CNT_W'(MAX_DELIM_LEN);
        end
        else
        begin
            r = CNT_W'(int'(len));
        end
        return r;
    endfunction

    // Entry 0 is the newest byte, so the pattern's first byte sits at len-1.
    function automatic logic win_match(input byte_win_t w,
                                       input logic [CNT_W-1:0] fill,
                                       input logic [CFG_DATA_W-1:0] pat,
                                       input logic [CNT_W-1:0] len);
        logic             ok;
        logic [IDX_W-1:0] sel;
        ok = (fill >= len);
        for (int i = 0; i < MAX_DELIM_LEN; i++)
        begin
            if (i < int'(len))
            begin
                sel = IDX_W'(int'(len) - 1 - i);
                if (w[i] != pat_byte(pat, int'(sel)))
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pattern_reg  <= '0;
            left_length_reg   <= LEN_W'(1);
            right_pattern_reg <= '0;
            right_length_reg  <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT_PATTERN:  left_pattern_reg  <= cfg_wdata;
                CFG_LEFT_LENGTH:   left_length_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_RIGHT_PATTERN: right_pattern_reg <= cfg_wdata;
                CFG_RIGHT_LENGTH:  right_length_reg  <= cfg_wdata[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEFT;
            fill_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
        end
    end

    // Bytes beyond the fill count are never looked at, so the window needs no reset.
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign text_in.ready = !q_full;
    assign accept        = text_in.valid && text_in.ready;

    always_comb
    begin
        win_shift[0] = text_in.data_byte;
        for (int i = 1; i < MAX_DELIM_LEN; i++)
        begin
            win_shift[i] = win_reg[i-1];
        end
        fill_shift = (fill_reg == CNT_W'(MAX_DELIM_LEN)) ? fill_reg : fill_reg + 1'b1;
    end

    assign ll        = eff_len(left_length_reg);
    assign rl        = eff_len(right_length_reg);
    assign rl_idx    = IDX_W'(int'(rl) - 1);
    assign left_hit  = win_match(win_shift, fill_shift, left_pattern_reg, ll);
    assign right_hit = win_match(win_shift, fill_shift, right_pattern_reg, rl);

    always_comb
    begin
        phase_next        = phase_reg;
        win_next          = win_reg;
        fill_next         = fill_reg;
        q_entry.span_v    = 1'b0;
        q_entry.span_byte = 8'd0;
        q_entry.end_v     = 1'b0;
        q_entry.found     = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_DONE:
                begin
                    // Rest of the text after a completed span is dropped.
                    if (text_in.final_byte)
                    begin
                        phase_next = PH_LEFT;
                        fill_next  = '0;
                    end
                end
                PH_RIGHT:
                begin
                    // The oldest held-back byte leaves once the window holds a full delimiter.
                    q_entry.span_v    = (fill_reg >= rl);
                    q_entry.span_byte = win_reg[rl_idx];
                    win_next          = win_shift;
                    fill_next         = fill_shift;
                    if (right_hit)
                    begin
                        q_entry.end_v = 1'b1;
                        q_entry.found = 1'b1;
                        fill_next     = '0;
                        phase_next    = text_in.final_byte ? PH_LEFT : PH_DONE;
                    end
                    else if (text_in.final_byte)
                    begin
                        q_entry.end_v = 1'b1;
                        fill_next     = '0;
                        phase_next    = PH_LEFT;
                    end
                end
                default:
                begin
                    win_next   = win_shift;
                    fill_next  = fill_shift;
                    phase_next = PH_LEFT;
                    if (left_hit)
                    begin
                        fill_next  = '0;
                        phase_next = PH_RIGHT;
                    end
                    if (text_in.final_byte)
                    begin
                        q_entry.end_v = 1'b1;
                        fill_next     = '0;
                        phase_next    = PH_LEFT;
                    end
                end
            endcase
        end
    end

    assign q_push = accept && (q_entry.span_v || q_entry.end_v);

endmodule
`default_nettype wire

>>> rtl/dse_queue.sv
`default_nettype none
// ============================================================================
// dse_queue
// Short first-in first-out queue of result pairs between front and back.
// ============================================================================
module dse_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire dse_pkg::result_pair_t push_entry,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       head_valid,
    output dse_pkg::result_pair_t      head_entry
);
    import dse_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_pair_t     entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (int'(p) == QUEUE_DEPTH - 1)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule
`default_nettype wire

>>> rtl/dse_back.sv
`default_nettype none
// ============================================================================
// dse_back
// Takes result pairs from the queue and delivers them one result a cycle
// while the sink is ready, span byte first, end result second.
// ============================================================================
module dse_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire dse_pkg::result_pair_t head_entry,
    output logic                       pop,
    dse_out_if.source                  span_out
);
    import dse_pkg::*;

    logic       span_v_reg, span_v_next;
    logic       end_v_reg, end_v_next;
    logic [7:0] byte_reg, byte_next;
    logic       found_reg, found_next;
    logic       handshake;
    logic       cur_empty;
    logic       last_out;

    assign handshake = span_out.valid && span_out.ready;
    assign cur_empty = !span_v_reg && !end_v_reg;
    // The held pair finishes this cycle when its only remaining result is taken.
    assign last_out  = handshake && (span_v_reg ^ end_v_reg);
    assign pop       = head_valid && (cur_empty || last_out);

    always_comb
    begin
        span_v_next = span_v_reg;
        end_v_next  = end_v_reg;
        byte_next   = byte_reg;
        found_next  = found_reg;
        if (pop)
        begin
            span_v_next = head_entry.span_v;
            end_v_next  = head_entry.end_v;
            byte_next   = head_entry.span_byte;
            found_next  = head_entry.found;
        end
        else if (handshake)
        begin
            if (span_v_reg)
            begin
                span_v_next = 1'b0;
            end
            else
            begin
                end_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_v_reg <= 1'b0;
            end_v_reg  <= 1'b0;
        end
        else
        begin
            span_v_reg <= span_v_next;
            end_v_reg  <= end_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        found_reg <= found_next;
    end

    assign span_out.valid     = span_v_reg || end_v_reg;
    assign span_out.span_byte = span_v_reg ? byte_reg : 8'd0;
    assign span_out.is_end    = !span_v_reg;
    assign span_out.found     = !span_v_reg && found_reg;

    a_span_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (span_out.valid && !span_out.is_end) |-> !span_out.found)
        else $error("span byte result carries a found flag");

    a_end_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (span_out.valid && span_out.is_end) |-> (span_out.span_byte == 8'd0))
        else $error("end result carries a nonzero byte");

    a_end_follows_span: assert property (@(posedge clk) disable iff (!rst_n)
        (handshake && span_v_reg && end_v_reg) |=> (span_out.valid && span_out.is_end))
        else $error("end result of a pair was lost after its span byte");

endmodule
`default_nettype wire

>>> rtl/delimited_span_extractor.sv
`default_nettype none
// ============================================================================
// delimited_span_extractor
// Streams text bytes and emits the bytes between a left and right delimiter.
// ============================================================================
// The block takes one text byte per cycle on text_in while the queue has
// room, and answers on span_out with span byte results and one end result
// per search. A byte is matched against both delimiters the cycle it is
// taken, in a window of the newest MAX_DELIM_LEN bytes, and its results
// pass a four-entry queue to an output stage that delivers one result per
// cycle while the sink is ready. A byte yields at most two results (a span
// byte and an end result); the block sustains one byte per cycle as long as
// the sink takes every result, and a byte with two results holds the output
// for both, which the queue absorbs. Span bytes lag the input by the right
// delimiter length. If an end result reports found low, the span bytes sent
// in that search are to be discarded. Configuration is written through
// cfg_we, cfg_index and cfg_wdata while no request is in flight.
module delimited_span_extractor #(
    parameter int MAX_DELIM_LEN = dse_pkg::DEFAULT_MAX_DELIM_LEN
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dse_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    dse_in_if.sink                                text_in,
    dse_out_if.source                             span_out
);
    import dse_pkg::*;

    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_head_valid;
    result_pair_t q_push_entry;
    result_pair_t q_head_entry;

    dse_front #(
        .MAX_DELIM_LEN (MAX_DELIM_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .text_in   (text_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    dse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    dse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .span_out   (span_out)
    );

endmodule
`default_nettype wire
